>>> hw/rtl/lbft_pkg.sv
// Shared types and constants for the learning bridge forwarding table.
package lbft_pkg;

  // Fixed field widths of the frame and result transactions.
  localparam int ADDR_FIELD_W = 48;
  localparam int PORT_W       = 16;

  // Defaults for the top-level parameters.
  localparam int LBFT_TABLE_DEPTH  = 128;
  localparam int LBFT_ADDRESS_BITS = 48;

  // Forwarding decision codes.
  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_DROP    = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the accepted frame
    logic lookup;   // compare, learn the source, read the destination port
    logic load;     // write the decision into the result register
  } lbft_cmd_t;

endpackage

>>> hw/rtl/learning_bridge_forward_table.sv
// Top level of the learning bridge forwarding table.
// Each frame transaction carries a source address, its arrival port and a
// destination address, and produces one result transaction. The source is
// learned first: if no valid entry holds it, address and arrival port go
// into the entry at a round-robin write pointer, which overwrites the
// oldest entry once the table is full; a known source keeps its old port.
// The destination is then looked up in the updated table: no match floods,
// a stored port equal to the arrival port drops, anything else forwards to
// the stored port (out_port is 0 for flood and drop). Only the low
// ADDRESS_BITS of each address take part. An accepted frame is registered;
// the lookup state then compares both addresses against every entry in
// parallel, learns the source and reads the destination port from the port
// memory; the result state forms the decision into the result register,
// waiting while a stalled result is held, and accepts the next frame as it
// loads. Entries become valid in write-pointer order, so a fill count
// replaces per-entry valid bits and no clearing pass follows reset.
module learning_bridge_forward_table
  import lbft_pkg::*;
#(
  parameter int TABLE_DEPTH  = LBFT_TABLE_DEPTH,
  parameter int ADDRESS_BITS = LBFT_ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // Frame channel
  input  logic                    frame_valid,
  output logic                    frame_stall,
  input  logic [ADDR_FIELD_W-1:0] src_address,
  input  logic [PORT_W-1:0]       arrival_port,
  input  logic [ADDR_FIELD_W-1:0] dst_address,
  // Result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [1:0]              action,
  output logic [PORT_W-1:0]       out_port,
  output logic                    learned
);

  lbft_cmd_t cmd;

  // Sequence each frame: capture, lookup/learn, load result.
  lbft_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // Hold the table and compute the forwarding decision.
  lbft_dpath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .src_address  (src_address),
    .arrival_port (arrival_port),
    .dst_address  (dst_address),
    .action       (action),
    .out_port     (out_port),
    .learned      (learned)
  );

endmodule

>>> hw/rtl/lbft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbft_ram
  import lbft_pkg::*;
#(
  parameter int WIDTH = PORT_W,
  parameter int DEPTH = LBFT_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lbft_ctrl.sv
// Controller state machine: frame handshake, sequencing and result valid.
module lbft_ctrl
  import lbft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      frame_valid,
  output logic      frame_stall,
  output logic      result_valid,
  input  logic      result_stall,
  output lbft_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_RES  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  // Result register can take a new value when empty or being drained.
  assign out_free    = !result_valid || !result_stall;
  assign frame_stall = !((state == ST_IDLE) || ((state == ST_RES) && out_free));
  assign accept      = frame_valid && !frame_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_RES;
      end
      ST_RES: begin
        if (out_free) state_next = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture = accept;
    cmd.lookup  = (state == ST_CMP);
    cmd.load    = (state == ST_RES) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lbft_dpath.sv
// Datapath: address compare array, port memory, learning and decision logic.
module lbft_dpath
  import lbft_pkg::*;
#(
  parameter int TABLE_DEPTH  = LBFT_TABLE_DEPTH,
  parameter int ADDRESS_BITS = LBFT_ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lbft_cmd_t               cmd,
  input  logic [ADDR_FIELD_W-1:0] src_address,
  input  logic [PORT_W-1:0]       arrival_port,
  input  logic [ADDR_FIELD_W-1:0] dst_address,
  output logic [1:0]              action,
  output logic [PORT_W-1:0]       out_port,
  output logic                    learned
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Keys: low ADDRESS_BITS of each address, zero above the field width.
  logic [ADDRESS_BITS-1:0] src_key_c;
  logic [ADDRESS_BITS-1:0] dst_key_c;

  for (genvar gb = 0; gb < ADDRESS_BITS; gb++) begin : g_key
    if (gb < ADDR_FIELD_W) begin : g_bit
      assign src_key_c[gb] = src_address[gb];
      assign dst_key_c[gb] = dst_address[gb];
    end else begin : g_zero
      assign src_key_c[gb] = 1'b0;
      assign dst_key_c[gb] = 1'b0;
    end
  end

  // Captured frame.
  logic [ADDRESS_BITS-1:0] src_key;
  logic [ADDRESS_BITS-1:0] dst_key;
  logic [PORT_W-1:0]       arr_port;

  // Table state.
  logic [ADDRESS_BITS-1:0] cam [TABLE_DEPTH];
  logic [IDX_W-1:0]        wp;
  logic                    full;

  // Lookup flags.
  logic learn_r;
  logic dst_hit_r;
  logic dst_at_wp_r;
  logic self_r;

  // Result register.
  action_t           action_q;
  logic [PORT_W-1:0] out_port_q;
  logic              learned_q;

  logic [TABLE_DEPTH-1:0] ent_valid;
  logic [TABLE_DEPTH-1:0] src_match;
  logic [TABLE_DEPTH-1:0] dst_match;
  logic                   src_hit_c;
  logic                   dst_hit_c;
  logic [IDX_W-1:0]       dst_idx_c;
  logic [PORT_W-1:0]      ram_rdata;
  logic                   learn_c;

  logic              hit_c;
  logic [PORT_W-1:0] hit_port_c;
  action_t           action_c;
  logic [PORT_W-1:0] oport_c;

  // Entries fill in write-pointer order, so the fill count gives validity.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ent_valid[i] = full || (IDX_W'(i) < wp);
      src_match[i] = ent_valid[i] && (cam[i] == src_key);
      dst_match[i] = ent_valid[i] && (cam[i] == dst_key);
    end
  end

  // Valid addresses are unique, so at most one match: OR-encode the index.
  always_comb begin
    dst_idx_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (dst_match[i]) dst_idx_c = dst_idx_c | IDX_W'(i);
    end
  end

  assign src_hit_c = |src_match;
  assign dst_hit_c = |dst_match;
  assign learn_c   = cmd.lookup && !src_hit_c;

  lbft_ram #(
    .WIDTH (PORT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_port_ram (
    .clk   (clk),
    .we    (learn_c),
    .waddr (wp),
    .wdata (arr_port),
    .re    (cmd.lookup),
    .raddr (dst_idx_c),
    .rdata (ram_rdata)
  );

  // Decide against the table as it stands after learning.
  always_comb begin
    priority if (learn_r && self_r) begin
      hit_c      = 1'b1;
      hit_port_c = arr_port;
    end else if (dst_hit_r && !(learn_r && dst_at_wp_r)) begin
      hit_c      = 1'b1;
      hit_port_c = ram_rdata;
    end else begin
      hit_c      = 1'b0;
      hit_port_c = '0;
    end

    if (!hit_c) begin
      action_c = ACT_FLOOD;
      oport_c  = '0;
    end else if (hit_port_c == arr_port) begin
      action_c = ACT_DROP;
      oport_c  = '0;
    end else begin
      action_c = ACT_FORWARD;
      oport_c  = hit_port_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (learn_c) begin
      if (wp == LAST_IDX) begin
        wp   <= '0;
        full <= 1'b1;
      end else begin
        wp <= wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_key  <= src_key_c;
      dst_key  <= dst_key_c;
      arr_port <= arrival_port;
    end
    if (learn_c) begin
      cam[wp] <= src_key;
    end
    if (cmd.lookup) begin
      learn_r     <= !src_hit_c;
      dst_hit_r   <= dst_hit_c;
      dst_at_wp_r <= dst_match[wp];
      self_r      <= (src_key == dst_key);
    end
    if (cmd.load) begin
      action_q   <= action_c;
      out_port_q <= oport_c;
      learned_q  <= learn_r;
    end
  end

  assign action   = action_q;
  assign out_port = out_port_q;
  assign learned  = learned_q;

endmodule

>>> hw/rtl/lbft_checker.sv
// Port-level assertions for the forwarding table, bound to the top level.
module lbft_checker
  import lbft_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    frame_valid,
  input logic                    frame_stall,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic [1:0]              action,
  input logic [PORT_W-1:0]       out_port,
  input logic                    learned
);

  // Hold a stalled result transaction.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(action) && $stable(out_port) && $stable(learned))
    else $error("stalled result transaction changed");

  // A frame occupies the lookup cycle, so no two accepts back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("frame accepted during lookup cycle");

  // Only defined decision codes leave the block.
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (action == ACT_FORWARD) || (action == ACT_FLOOD) ||
                     (action == ACT_DROP))
    else $error("undefined action code");

  // Flood and drop carry no port.
  a_port_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (action != ACT_FORWARD) |-> out_port == '0)
    else $error("out_port nonzero on flood or drop");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind learning_bridge_forward_table lbft_checker u_lbft_checker (.*);
